@@ src/spm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spm_pkg - shared types and constants of the stripe page mapper
// Holds the operation and result-kind codes, the fixed field widths and the
// structs that travel between the front end, the task queue and the back end.
// ----------------------------------------------------------------------------
package spm_pkg;

    // Operation codes on the request side
    localparam logic [5:0] OP_READ  = 6'd0;
    localparam logic [5:0] OP_WRITE = 6'd1;

    // Result kinds
    localparam logic [1:0] KIND_READ  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;

    // Widths settled by the largest legal parameter values
    localparam int DISK_W = 4;   // up to 16 devices
    localparam int OFF_W  = 10;  // stripe offset, up to 1024 pages per stripe
    localparam int CNT_W  = 7;   // page count, 0 .. 127 after flooring
    localparam int REM_W  = 14;  // remainder of start page modulo one full row
    localparam int BUF_W  = 6;   // page index inside the request buffer

    // Page size as a shift: 4096 bytes per page
    localparam int PAGE_SHIFT = 12;

    // Task queue depth
    localparam int QUEUE_DEPTH = 2;

    // One decoded request, handed from front to back
    typedef struct packed {
        logic [31:0]       tag;
        logic [1:0]        kind;
        logic [DISK_W-1:0] disk;
        logic [OFF_W-1:0]  offset;
        logic [31:0]       base;
        logic [CNT_W-1:0]  npages;
        logic              clipped;
    } task_t;

    // One result beat
    typedef struct packed {
        logic [31:0]      tag;
        logic [1:0]       kind;
        logic [1:0]       disk;
        logic [31:0]      disk_page;
        logic [BUF_W-1:0] buffer_page;
        logic             clipped;
        logic             last;
    } result_t;

endpackage
`default_nettype wire

@@ src/stripe_page_mapper_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// stripe_page_mapper_unit - RAID-0 striping address map
// Splits block requests into per-page results addressed to striped disks.
// ----------------------------------------------------------------------------
// A request beat carries an id, an operation, a start page and a length in
// bytes. Reads and writes produce one result beat per whole page (length
// floored to 4 KiB and clipped to MAX_PAGES, with clipped set on every beat
// of a clipped request); page p goes to disk (p/STRIPE_PAGES) mod DEVICES at
// disk page (stripe/DEVICES)*STRIPE_PAGES + p mod STRIPE_PAGES. Any other
// operation, or a read or write shorter than a page, gives one no-transfer
// beat. For a read or write the front end accepts the request, multiplies the
// start page, 16 bits at a time in a low and a high step, by the reciprocal
// of a full row of stripes, forms the row and the remainder, and hands the
// task over; a no-transfer request goes from accept straight to hand-over. It
// takes no new request until the hand-over is done, and the hand-over holds
// while the queue is full. A two-entry task queue sits between the front end
// and the page walker, which emits one page beat per cycle while the output
// is not stalled, and pauses between one request and the next.
// ----------------------------------------------------------------------------
module stripe_page_mapper_unit #(
    parameter int DEVICES      = 4,
    parameter int STRIPE_PAGES = 32,
    parameter int MAX_PAGES    = 64
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    // request_id[31:0], op[37:32], start_page[69:38], length_bytes[88:70], zero[95:89]
    input  wire  [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // tag[31:0], disk[33:32], disk_page[65:34], buffer_page[71:66], clipped[72],
    // zero[79:73]
    output logic [79:0] m_axis_tdata,
    // kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import spm_pkg::*;

    logic    fq_valid;
    logic    fq_ready;
    task_t   fq_data;
    logic    qb_valid;
    logic    qb_ready;
    task_t   qb_data;
    result_t res;

    // Front end: take the request beat apart and decode it
    spm_front #(
        .DEVICES      (DEVICES),
        .STRIPE_PAGES (STRIPE_PAGES),
        .MAX_PAGES    (MAX_PAGES)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_axis_tvalid),
        .req_ready  (s_axis_tready),
        .req_id     (s_axis_tdata[31:0]),
        .req_op     (s_axis_tdata[37:32]),
        .req_start  (s_axis_tdata[69:38]),
        .req_len    (s_axis_tdata[88:70]),
        .task_valid (fq_valid),
        .task_ready (fq_ready),
        .task_data  (fq_data)
    );

    // Hold decoded tasks while the walker is busy
    spm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_data  (fq_data),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_data   (qb_data)
    );

    // Back end: walk the pages, one result beat per cycle while the output is not stalled
    spm_back #(
        .DEVICES      (DEVICES),
        .STRIPE_PAGES (STRIPE_PAGES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .task_valid (qb_valid),
        .task_ready (qb_ready),
        .task_data  (qb_data),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_data   (res)
    );

    // Pack the result beat
    assign m_axis_tdata = {7'd0, res.clipped, res.buffer_page, res.disk_page,
                           res.disk, res.tag};
    assign m_axis_tuser = res.kind;
    assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

@@ src/spm_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spm_front - request intake and address decomposition
// Accepts a request, classifies it, splits the start page into row, disk and
// stripe offset by a reciprocal multiplication, and pushes one task to the queue.
// ----------------------------------------------------------------------------
module spm_front #(
    parameter int DEVICES      = 4,
    parameter int STRIPE_PAGES = 32,
    parameter int MAX_PAGES    = 64
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_ready,
    input  wire  [31:0]         req_id,
    input  wire  [5:0]          req_op,
    input  wire  [31:0]         req_start,
    input  wire  [18:0]         req_len,
    output logic                task_valid,
    input  wire                 task_ready,
    output spm_pkg::task_t      task_data
);
    import spm_pkg::*;

    localparam int ROW_PAGES   = STRIPE_PAGES * DEVICES;
    // x / ROW_PAGES == (x * RECIP) >> RECIP_SHIFT for every 32-bit x
    localparam int RECIP_SHIFT = 32 + $clog2(ROW_PAGES);
    localparam longint unsigned RECIP =
        ((64'd1 << RECIP_SHIFT) + 64'(ROW_PAGES) - 64'd1) / 64'(ROW_PAGES);
    localparam logic [32:0] RECIP_C = 33'(RECIP);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_MUL_LO = 5'b00010,
        S_MUL_HI = 5'b00100,
        S_SPLIT  = 5'b01000,
        S_PUSH   = 5'b10000
    } fstate_t;

    fstate_t           state_reg, state_next;
    logic [31:0]       dvd_reg, dvd_next;
    logic [64:0]       prod_reg, prod_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [31:0]       tag_reg, tag_next;
    logic [1:0]        kind_reg, kind_next;
    logic [CNT_W-1:0]  npages_reg, npages_next;
    logic              clip_reg, clip_next;
    logic              xfer_reg, xfer_next;

    logic [CNT_W-1:0]  pages;
    logic              is_xfer;
    logic [15:0]       mul_in;
    logic [48:0]       mul_out;
    logic [31:0]       quot;
    logic [31:0]       row_start;
    logic [REM_W:0]    small_rem;
    logic [DISK_W-1:0] disk_q;
    logic [31:0]       row_base;

    assign pages   = req_len[PAGE_SHIFT +: CNT_W];
    assign is_xfer = ((req_op == OP_READ) || (req_op == OP_WRITE)) && (pages != '0);

    // One 16 x 33 multiplier, used on the low then the high half of the start page
    assign mul_in  = (state_reg == S_MUL_HI) ? dvd_reg[31:16] : dvd_reg[15:0];
    assign mul_out = 49'(mul_in) * 49'(RECIP_C);

    // Row number and the first page of that row
    assign quot      = 32'(prod_reg >> RECIP_SHIFT);
    assign row_start = 32'(quot * 32'(ROW_PAGES));

    // Remainder of a row split into disk and stripe offset (few narrow steps)
    always_comb
    begin
        small_rem = {1'b0, rem_reg};
        disk_q    = '0;
        for (int k = DISK_W - 1; k >= 0; k--)
        begin
            if (small_rem >= ((REM_W+1)'(STRIPE_PAGES) << k))
            begin
                small_rem = small_rem - ((REM_W+1)'(STRIPE_PAGES) << k);
                disk_q[k] = 1'b1;
            end
        end
    end

    assign row_base = 32'(dvd_reg * 32'(STRIPE_PAGES));

    always_comb
    begin
        state_next  = state_reg;
        dvd_next    = dvd_reg;
        prod_next   = prod_reg;
        rem_next    = rem_reg;
        tag_next    = tag_reg;
        kind_next   = kind_reg;
        npages_next = npages_reg;
        clip_next   = clip_reg;
        xfer_next   = xfer_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    tag_next  = req_id;
                    dvd_next  = req_start;
                    rem_next  = '0;
                    xfer_next = is_xfer;
                    if (is_xfer)
                    begin
                        kind_next = req_op[1:0];
                        if (pages > CNT_W'(MAX_PAGES))
                        begin
                            npages_next = CNT_W'(MAX_PAGES);
                            clip_next   = 1'b1;
                        end
                        else
                        begin
                            npages_next = pages;
                            clip_next   = 1'b0;
                        end
                        state_next = S_MUL_LO;
                    end
                    else
                    begin
                        kind_next   = KIND_NONE;
                        npages_next = CNT_W'(1);
                        clip_next   = 1'b0;
                        state_next  = S_PUSH;
                    end
                end
            end
            S_MUL_LO:
            begin
                prod_next  = 65'(mul_out);
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                prod_next  = prod_reg + (65'(mul_out) << 16);
                state_next = S_SPLIT;
            end
            S_SPLIT:
            begin
                // keep the row number, and the page's place inside its row
                rem_next   = REM_W'(dvd_reg - row_start);
                dvd_next   = quot;
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (task_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_ready  = (state_reg == S_IDLE);
    assign task_valid = (state_reg == S_PUSH);

    always_comb
    begin
        task_data.tag     = tag_reg;
        task_data.kind    = kind_reg;
        task_data.npages  = npages_reg;
        task_data.clipped = clip_reg;
        if (xfer_reg)
        begin
            task_data.disk   = disk_q;
            task_data.offset = small_rem[OFF_W-1:0];
            task_data.base   = row_base;
        end
        else
        begin
            task_data.disk   = '0;
            task_data.offset = '0;
            task_data.base   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        prod_reg   <= prod_next;
        rem_reg    <= rem_next;
        tag_reg    <= tag_next;
        kind_reg   <= kind_next;
        npages_reg <= npages_next;
        clip_reg   <= clip_next;
        xfer_reg   <= xfer_next;
    end

endmodule
`default_nettype wire

@@ src/spm_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spm_queue - short task queue between front and back
// Lets the front end decode the next request while the back end still
// emits pages of the previous one.
// ----------------------------------------------------------------------------
module spm_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_valid,
    output logic                push_ready,
    input  spm_pkg::task_t      push_data,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output spm_pkg::task_t      pop_data
);
    import spm_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

    task_t              mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0]  count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_QW'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ src/spm_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// spm_back - page walker
// Takes one task at a time and emits one result per page, stepping the
// stripe offset, disk index and row base without any division.
// ----------------------------------------------------------------------------
module spm_back #(
    parameter int DEVICES      = 4,
    parameter int STRIPE_PAGES = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 task_valid,
    output logic                task_ready,
    input  spm_pkg::task_t      task_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output spm_pkg::result_t    out_data
);
    import spm_pkg::*;

    logic              active_reg, active_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_data_reg, out_data_next;
    task_t             cur_reg, cur_next;
    logic [BUF_W-1:0]  idx_reg, idx_next;

    logic              issue;
    logic              last_page;

    assign task_ready = !active_reg;
    assign issue      = active_reg && (!out_valid_reg || out_ready);
    assign last_page  = ((CNT_W'(idx_reg) + 1'b1) == cur_reg.npages);

    always_comb
    begin
        active_next    = active_reg;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (task_valid && !active_reg)
        begin
            cur_next    = task_data;
            idx_next    = '0;
            active_next = 1'b1;
        end
        if (issue)
        begin
            out_valid_next            = 1'b1;
            out_data_next.tag         = cur_reg.tag;
            out_data_next.kind        = cur_reg.kind;
            out_data_next.disk        = cur_reg.disk[1:0];
            out_data_next.disk_page   = cur_reg.base + 32'(cur_reg.offset);
            out_data_next.buffer_page = idx_reg;
            out_data_next.clipped     = cur_reg.clipped;
            out_data_next.last        = last_page;
            if (last_page)
            begin
                active_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
                // advance along the stripe, then to the next disk, then the next row
                if (cur_reg.offset == OFF_W'(STRIPE_PAGES - 1))
                begin
                    cur_next.offset = '0;
                    if (cur_reg.disk == DISK_W'(DEVICES - 1))
                    begin
                        cur_next.disk = '0;
                        cur_next.base = cur_reg.base + 32'(STRIPE_PAGES);
                    end
                    else
                    begin
                        cur_next.disk = cur_reg.disk + 1'b1;
                    end
                end
                else
                begin
                    cur_next.offset = cur_reg.offset + 1'b1;
                end
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg      <= cur_next;
        idx_reg      <= idx_next;
        out_data_reg <= out_data_next;
    end

`ifndef NO_ASSERTIONS
    a_none_single : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.kind == KIND_NONE))
            |-> (out_data_reg.last && (out_data_reg.buffer_page == '0)))
        else $error("no-transfer result is not a single last beat");

    a_idx_range : assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (CNT_W'(idx_reg) < cur_reg.npages))
        else $error("page index ran past the page count");

    a_last_ends : assert property (@(posedge clk) disable iff (!rst_n)
        (issue && last_page) |=> (!active_reg && out_valid_reg && out_data_reg.last))
        else $error("last page did not close the task");
`endif

endmodule
`default_nettype wire
